@@ rtl/core/crct_pkg.sv @@
// ----------------------------------------------------------------------------
// crct_pkg
// Shared types and constants of the Catmull-Rom curve tessellator.
// ----------------------------------------------------------------------------
package crct_pkg;

  localparam int unsigned DivWidth   = 5;
  localparam int unsigned DivReset   = 8;
  localparam int unsigned AddrWidth  = 2;
  localparam logic [AddrWidth-1:0] RegDivisions = 2'd0;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG_SETUP,
    ST_COEF,
    ST_HORNER,
    ST_OUT,
    ST_FINAL
  } state_e;

  // Jobs queued by one request: the segment closed by the held point, the
  // segment closed by a final point, the flush segment and the end point.
  typedef struct packed {
    logic seg_a;
    logic seg_m;
    logic seg_b;
    logic emit_end;
  } job_t;

endpackage

@@ rtl/core/crct_stream_if.sv @@
// ----------------------------------------------------------------------------
// crct_stream_if
// Valid/ready channel carrying one payload of a parameterized type.
// ----------------------------------------------------------------------------
interface crct_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/catmull_rom_curve_tessellator.sv @@
// ----------------------------------------------------------------------------
// catmull_rom_curve_tessellator
// Streaming Catmull-Rom tessellator built around one shared multiplier.
// ----------------------------------------------------------------------------
// One control point request is taken when the block is idle. A request can
// close up to three segments of D samples (D is the effective division count)
// and, when it carries the final point of a curve, the end point. Each sample
// goes through a restoring divider that builds the time step floor(j*65536/D),
// a load step, nine Horner steps on the single shared multiplier (three for
// each of three axes) and an output step. Each segment adds a setup step, and
// the next request is taken only once all segments and the end point of the
// current one are done. A request that produces no result passes only through
// the setup state. A stalled output holds the sequencer until the pending
// sample is taken.
module catmull_rom_curve_tessellator #(
  parameter int unsigned COORD_WIDTH   = 24,
  parameter int unsigned MAX_DIVISIONS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  crct_stream_if.sink   in_if,
  crct_stream_if.source out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [crct_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import crct_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned HW = CW + 8;   // Horner accumulator width
  localparam int unsigned PW = HW + 17;  // product width
  localparam logic signed [CW-1:0] CMax = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMin = {1'b1, {(CW-1){1'b0}}};

  // --------------------------------------------------------------- config
  logic [DivWidth-1:0] div_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= DivWidth'(DivReset);
    end else if (psel && penable && pwrite && paddr == RegDivisions) begin
      div_q <= pwdata[DivWidth-1:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == RegDivisions) ? {{(32-DivWidth){1'b0}}, div_q} : 32'd0;

  logic [DivWidth-1:0] deff;
  always_comb begin
    if (div_q == '0) deff = DivWidth'(1);
    else if (32'(div_q) > MAX_DIVISIONS) deff = DivWidth'(MAX_DIVISIONS);
    else deff = div_q;
  end

  // ---------------------------------------------------------------- state
  logic signed [CW-1:0] win_q [9];
  logic signed [CW-1:0] held_q [3];
  logic                 hsm_q;
  logic [2:0]           seen_q;

  state_e st_q, st_d;
  job_t   job_q;
  logic   fin_q;                         // request was final
  logic [2:0] cnt_q;                     // points seen before the request
  logic signed [CW-1:0] raw_q [3];       // raw point of the request
  // Segment points p0..p3 per axis, latched when the request is taken or at segment setup.
  logic signed [CW-1:0] sp_q [4][3];
  logic signed [HW-1:0] c3_q [3], c2_q [3], c1_q [3], c0_q [3];
  logic signed [HW-1:0] h_q;
  logic signed [CW-1:0] smp_q [3];
  logic [DivWidth-1:0]  j_q;
  logic [16:0]          t_q;
  logic [1:0]           ax_q, step_q;
  logic [4:0]           bit_q;           // divider bit counter
  logic [DivWidth+16:0] rem_q;
  logic                 tdone_q;

  // Output register.
  logic                 ov_q;
  logic signed [CW-1:0] ox_q, oy_q, oz_q;
  logic                 olast_q, oeoc_q;

  assign out_if.valid            = ov_q;
  assign out_if.data.out_x       = ox_q;
  assign out_if.data.out_y       = oy_q;
  assign out_if.data.out_z       = oz_q;
  assign out_if.data.last_of_run = olast_q;
  assign out_if.data.end_of_curve = oeoc_q;
  wire out_free = !ov_q || out_if.ready;
  wire out_load = out_free && (st_q == ST_OUT || st_q == ST_FINAL);

  assign in_if.ready = (st_q == ST_IDLE);
  wire acc = in_if.valid && in_if.ready;

  // Processed point q (held point, maybe smoothed).
  logic signed [CW-1:0] rin [3];
  logic signed [CW-1:0] qpt [3];
  always_comb begin
    rin[0] = in_if.data.coord_x;
    rin[1] = in_if.data.coord_y;
    rin[2] = in_if.data.coord_z;
    for (int a = 0; a < 3; a++) begin
      logic signed [CW:0] s;
      s = {held_q[a][CW-1], held_q[a]} + {rin[a][CW-1], rin[a]};
      qpt[a] = (seen_q >= 3'd2 && hsm_q) ? s[CW:1] : held_q[a];
    end
  end

  // Shared multiplier: Horner step h*T, floor shift by 16.
  logic signed [PW-1:0] prod;
  logic signed [HW-1:0] hstep;
  assign prod  = PW'(h_q) * $signed({1'b0, t_q});
  assign hstep = HW'(prod >>> 16);

  logic signed [HW-1:0] addc;
  always_comb begin
    unique case (step_q)
      2'd0:    addc = c2_q[ax_q];
      2'd1:    addc = c1_q[ax_q];
      default: addc = c0_q[ax_q];
    endcase
  end
  logic signed [HW-1:0] hnext;
  assign hnext = addc + hstep;
  logic signed [HW-2:0] half;
  assign half = hnext[HW-1:1];
  logic signed [CW-1:0] sat;
  always_comb begin
    if (half > (HW-1)'(CMax)) sat = CMax;
    else if (half < (HW-1)'(CMin)) sat = CMin;
    else sat = half[CW-1:0];
  end

  // Divider trial for T = floor(j*65536/D).
  logic [DivWidth+16:0] rtrial;
  assign rtrial = {rem_q[DivWidth+15:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= ST_IDLE;
    else st_q <= st_d;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:      if (acc) st_d = ST_SEG_SETUP;
      ST_SEG_SETUP: begin
        if (job_q.seg_a || job_q.seg_m || job_q.seg_b) st_d = ST_COEF;
        else if (job_q.emit_end) st_d = ST_FINAL;
        else st_d = ST_IDLE;
      end
      ST_COEF:      if (tdone_q) st_d = ST_HORNER;
      ST_HORNER:    if (ax_q == 2'd2 && step_q == 2'd2) st_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          if (j_q + 1'b1 < deff) st_d = ST_COEF;
          else st_d = ST_SEG_SETUP;
        end
      end
      ST_FINAL:     if (out_free) st_d = ST_IDLE;
      default:      st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
      for (int a = 0; a < 3; a++) held_q[a] <= '0;
      hsm_q  <= 1'b0;
      seen_q <= '0;
      job_q  <= '0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
      j_q    <= '0;
      ax_q   <= '0;
      step_q <= '0;
      bit_q  <= '0;
      tdone_q <= 1'b0;
    end else begin
      if (ov_q && out_if.ready && !out_load) ov_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: if (acc) begin
          logic [2:0] c;
          c = seen_q;
          for (int a = 0; a < 3; a++) raw_q[a] <= rin[a];
          fin_q <= in_if.data.final_point;
          cnt_q <= c;
          job_q.seg_a <= (c >= 3'd3);
          job_q.seg_m <= in_if.data.final_point && c >= 3'd2;
          job_q.seg_b <= in_if.data.final_point && c >= 3'd1;
          job_q.emit_end <= in_if.data.final_point;
          // Segment A (from the held point push) uses the window before the
          // shift: p0 = w0 (or w3 when only two came before), p1 = w3, p2 = w6.
          if (c >= 3'd3) begin
            for (int a = 0; a < 3; a++) begin
              sp_q[0][a] <= (c == 3'd3) ? win_q[3+a] : win_q[a];
              sp_q[1][a] <= win_q[3+a];
              sp_q[2][a] <= win_q[6+a];
              sp_q[3][a] <= qpt[a];
            end
          end
          // The processed held point enters the window. The raw final point
          // is taken from raw_q by the later segments instead.
          if (c >= 3'd1) begin
            for (int a = 0; a < 3; a++) begin
              win_q[a]   <= win_q[3+a];
              win_q[3+a] <= win_q[6+a];
              win_q[6+a] <= qpt[a];
            end
          end
          for (int a = 0; a < 3; a++) held_q[a] <= rin[a];
          hsm_q <= in_if.data.smooth;
          if (seen_q != 3'd7) seen_q <= seen_q + 3'd1;
        end
        ST_SEG_SETUP: begin
          j_q <= '0;
          if (job_q.seg_a) begin
            job_q.seg_a <= 1'b0;
          end else if (job_q.seg_m) begin
            // Segment that the final point completes as p3.
            job_q.seg_m <= 1'b0;
            for (int a = 0; a < 3; a++) begin
              sp_q[0][a] <= (cnt_q == 3'd2) ? win_q[3+a] : win_q[a];
              sp_q[1][a] <= win_q[3+a];
              sp_q[2][a] <= win_q[6+a];
              sp_q[3][a] <= raw_q[a];
            end
          end else if (job_q.seg_b) begin
            // Flush segment into the final point, whose tangent is clamped.
            job_q.seg_b <= 1'b0;
            for (int a = 0; a < 3; a++) begin
              sp_q[0][a] <= (cnt_q == 3'd1) ? win_q[6+a] : win_q[3+a];
              sp_q[1][a] <= win_q[6+a];
              sp_q[2][a] <= raw_q[a];
              sp_q[3][a] <= raw_q[a];
            end
          end
          if (job_q.seg_a || job_q.seg_m || job_q.seg_b) begin
            rem_q <= '0;
            bit_q <= '0;
            tdone_q <= 1'b0;
          end
        end
        ST_COEF: begin
          // Restoring division of j<<16 by D, one quotient bit per cycle;
          // coefficients are computed in the first division step of a segment's first sample.
          if (j_q == '0 && bit_q == '0) begin
            for (int a = 0; a < 3; a++) begin
              logic signed [HW-1:0] p0, p1, p2, p3, d0, d1;
              p0 = HW'(sp_q[0][a]); p1 = HW'(sp_q[1][a]);
              p2 = HW'(sp_q[2][a]); p3 = HW'(sp_q[3][a]);
              d0 = p2 - p0;
              d1 = p3 - p1;
              c0_q[a] <= p1 <<< 1;
              c1_q[a] <= d0;
              c2_q[a] <= (p2 - p1) * 6 - (d0 <<< 1) - d1;
              c3_q[a] <= ((p1 - p2) <<< 2) + d0 + d1;
            end
          end
          if (!tdone_q) begin
            logic [DivWidth+16:0] num, rt;
            num = {1'b0, j_q, 16'd0};
            rt  = rtrial | (DivWidth+17)'(num[DivWidth+16-bit_q]);
            if (rt >= (DivWidth+17)'(deff)) begin
              rem_q <= rt - (DivWidth+17)'(deff);
              t_q <= {t_q[15:0], 1'b1};
            end else begin
              rem_q <= rt;
              t_q <= (bit_q == '0) ? 17'd0 : {t_q[15:0], 1'b0};
            end
            if (32'(bit_q) == DivWidth + 16) tdone_q <= 1'b1;
            bit_q <= bit_q + 5'd1;
          end else begin
            ax_q   <= '0;
            step_q <= '0;
            h_q    <= c3_q[0];
          end
        end
        ST_HORNER: begin
          if (step_q == 2'd2) begin
            smp_q[ax_q] <= sat;
            step_q <= '0;
            if (ax_q != 2'd2) begin
              ax_q <= ax_q + 2'd1;
              h_q  <= c3_q[ax_q + 2'd1];
            end
          end else begin
            step_q <= step_q + 2'd1;
            h_q    <= hnext;
          end
        end
        ST_OUT: if (out_free) begin
          ov_q <= 1'b1;
          ox_q <= smp_q[0]; oy_q <= smp_q[1]; oz_q <= smp_q[2];
          oeoc_q  <= 1'b0;
          olast_q <= (j_q + 1'b1 >= deff) && !fin_q;
          j_q <= j_q + 1'b1;
          rem_q <= '0;
          bit_q <= '0;
          tdone_q <= 1'b0;
        end
        ST_FINAL: if (out_free) begin
          ov_q <= 1'b1;
          ox_q <= raw_q[0]; oy_q <= raw_q[1]; oz_q <= raw_q[2];
          oeoc_q  <= 1'b1;
          olast_q <= 1'b1;
          job_q.emit_end <= 1'b0;
          for (int i = 0; i < 9; i++) win_q[i] <= '0;
          for (int a = 0; a < 3; a++) held_q[a] <= '0;
          hsm_q  <= 1'b0;
          seen_q <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

@@ rtl/core/crct_checker.sv @@
// ----------------------------------------------------------------------------
// crct_checker
// Port-level checks of the tessellator, bound to the top level.
// ----------------------------------------------------------------------------
module crct_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_eoc_i,
  input logic out_last_i
);
  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
  // The end of a curve always closes the run.
  a_eoc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_eoc_i |-> out_last_i) else $error("eoc without last");
  // Taking a request makes the block busy in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i) else $error("ready after request");
endmodule

bind catmull_rom_curve_tessellator crct_checker u_crct_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_if.valid),
  .in_ready_i (in_if.ready),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .out_eoc_i  (out_if.data.end_of_curve),
  .out_last_i (out_if.data.last_of_run)
);
